// ===== hw/rtl/sgh_pkg.sv =====
// Package: shared widths, sequencer state and histogram port types.
package sgh_pkg;

    localparam int VALUE_W  = 16;
    localparam int DIV_W    = 7;
    localparam int COUNT_W  = 12;
    localparam int HIST_AW  = 6;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_RD    = 11'b000_0000_0010,
        ST_GST   = 11'b000_0000_0100,
        ST_GRUN  = 11'b000_0000_1000,
        ST_NEW   = 11'b000_0001_0000,
        ST_HRD   = 11'b000_0010_0000,
        ST_HWR   = 11'b000_0100_0000,
        ST_NXT   = 11'b000_1000_0000,
        ST_ERD   = 11'b001_0000_0000,
        ST_ELD   = 11'b010_0000_0000,
        ST_EWAIT = 11'b100_0000_0000
    } sgh_state_t;

    typedef struct packed {
        logic               clear;
        logic               rd_en;
        logic [HIST_AW-1:0] rd_addr;
        logic               wr_en;
        logic [HIST_AW-1:0] wr_addr;
        logic [COUNT_W-1:0] wr_data;
    } sgh_hist_ctrl_t;

endpackage

// ===== hw/rtl/sgh_intf.sv =====
// Interfaces: input and result word channels.
interface sgh_in_if;
    import sgh_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               last;
    modport source (output valid, value, last, input ready);
    modport sink (input valid, value, last, output ready);
endinterface

interface sgh_out_if;
    import sgh_pkg::*;
    logic               valid;
    logic               ready;
    logic [DIV_W-1:0]   divisor;
    logic [COUNT_W-1:0] count;
    logic               overflowed;
    logic               final_res;
    modport source (output valid, divisor, count, overflowed, final_res, input ready);
    modport sink (input valid, divisor, count, overflowed, final_res, output ready);
endinterface

// ===== hw/rtl/sgh_gcd_unit.sv =====
// Iterative binary GCD unit: one subtract or shift step per cycle.
module sgh_gcd_unit #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a_in,
    input  logic [W-1:0] b_in,
    output logic         done,
    output logic [W-1:0] result
);
    localparam int K_W = $clog2(W + 1);

    logic [W-1:0]   a_reg, a_next;
    logic [W-1:0]   b_reg, b_next;
    logic [K_W-1:0] k_reg, k_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [W-1:0]   res_reg, res_next;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (start)
        begin
            a_next    = a_in;
            b_next    = b_in;
            k_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (a_reg == '0 || b_reg == '0)
            begin
                res_next  = (a_reg | b_reg) << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
            end
            else if (a_reg >= b_reg)
            begin
                a_next = a_reg - b_reg;
            end
            else
            begin
                b_next = b_reg - a_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        k_reg   <= k_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule

// ===== hw/rtl/sgh_hist_mem.sv =====
// Histogram memory with per-bin valid bits; invalid bins read as zero.
module sgh_hist_mem #(
    parameter int MAX_LEN = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sgh_pkg::sgh_hist_ctrl_t         ctrl,
    output logic [sgh_pkg::COUNT_W-1:0]     rd_data
);
    import sgh_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEN);

    logic [COUNT_W-1:0] mem [MAX_LEN];
    logic [MAX_LEN-1:0] vld_reg;
    logic [COUNT_W-1:0] rd_data_reg;
    logic               rd_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                vld_reg <= '0;
            end
            else if (ctrl.wr_en)
            begin
                vld_reg[ctrl.wr_addr[IDX_W-1:0]] <= 1'b1;
            end
            if (ctrl.rd_en)
            begin
                rd_vld_reg <= vld_reg[ctrl.rd_addr[IDX_W-1:0]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr[IDX_W-1:0]] <= ctrl.wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[ctrl.rd_addr[IDX_W-1:0]];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;
endmodule

// ===== hw/rtl/subarray_gcd_histogram.sv =====
// Top level: subarray GCD histogram, sequencer and running-GCD memory.
// Per stored word: each older entry goes through read, GCD start, GCD run, histogram read
// and write, and next; the newest entry is written directly. Ready only in idle.
// On a last word: one result word per stored element (read, load, wait for output ready).
// Reset (async, rst_n low) clears control, counts, dropped flag and histogram valid
// bits at once; no clearing pass. Running GCD memory is not reset.
module subarray_gcd_histogram #(
    parameter int MAX_LEN    = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    sgh_in_if.sink          in_ch,
    sgh_out_if.source       out_ch
);
    import sgh_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    sgh_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    item_cnt_reg, item_cnt_next;
    logic                drop_reg, drop_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    d_reg, d_next;
    logic                last_reg, last_next;
    logic [VALUE_BITS-1:0] v_reg, v_next;
    logic [VALUE_BITS-1:0] g_reg, g_next;

    logic                out_valid_reg, out_valid_next;
    logic [DIV_W-1:0]    out_div_reg, out_div_next;
    logic [COUNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic                out_ovf_reg, out_ovf_next;
    logic                out_fin_reg, out_fin_next;

    logic [VALUE_BITS-1:0] gcd_mem [MAX_LEN];
    logic [VALUE_BITS-1:0] gcd_rd_reg;
    logic                  mem_rd_en;
    logic                  mem_wr_en;
    logic [VALUE_BITS-1:0] mem_wr_data;

    logic                  gcd_start;
    logic                  gcd_done;
    logic [VALUE_BITS-1:0] gcd_result;

    sgh_hist_ctrl_t        hist_ctrl;
    logic [COUNT_W-1:0]    hist_rd_data;

    logic [31:0]           in_value_ext;
    logic [31:0]           g_ext;
    logic [31:0]           g_m1;
    logic                  g_in_range;
    logic [CNT_W-1:0]      d_m1;
    logic [IDX_W-1:0]      idx_inc;

    assign in_value_ext = {16'b0, in_ch.value};
    assign g_ext        = 32'(g_reg);
    assign g_m1         = g_ext - 32'd1;
    assign g_in_range   = (g_ext != 32'd0) && (g_ext <= 32'(MAX_LEN));
    assign d_m1         = d_reg - 1'b1;
    assign idx_inc      = idx_reg + 1'b1;

    sgh_gcd_unit #(
        .W (VALUE_BITS)
    ) u_gcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (gcd_start),
        .a_in   (gcd_rd_reg),
        .b_in   (v_reg),
        .done   (gcd_done),
        .result (gcd_result)
    );

    sgh_hist_mem #(
        .MAX_LEN (MAX_LEN)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (hist_ctrl),
        .rd_data (hist_rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        item_cnt_next  = item_cnt_reg;
        drop_next      = drop_reg;
        idx_next       = idx_reg;
        d_next         = d_reg;
        last_next      = last_reg;
        v_next         = v_reg;
        g_next         = g_reg;
        out_valid_next = out_valid_reg;
        out_div_next   = out_div_reg;
        out_cnt_next   = out_cnt_reg;
        out_ovf_next   = out_ovf_reg;
        out_fin_next   = out_fin_reg;
        mem_rd_en      = 1'b0;
        mem_wr_en      = 1'b0;
        mem_wr_data    = v_reg;
        gcd_start      = 1'b0;
        hist_ctrl      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    v_next    = in_value_ext[VALUE_BITS-1:0];
                    last_next = in_ch.last;
                    if (item_cnt_reg < CNT_W'(MAX_LEN))
                    begin
                        idx_next   = '0;
                        state_next = (item_cnt_reg == '0) ? ST_NEW : ST_RD;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                        if (in_ch.last)
                        begin
                            d_next     = CNT_W'(1);
                            state_next = ST_ERD;
                        end
                    end
                end
            end
            ST_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = ST_GST;
            end
            ST_GST:
            begin
                gcd_start  = 1'b1;
                state_next = ST_GRUN;
            end
            ST_GRUN:
            begin
                if (gcd_done)
                begin
                    g_next      = gcd_result;
                    mem_wr_en   = 1'b1;
                    mem_wr_data = gcd_result;
                    state_next  = ST_HRD;
                end
            end
            ST_NEW:
            begin
                g_next      = v_reg;
                mem_wr_en   = 1'b1;
                mem_wr_data = v_reg;
                state_next  = ST_HRD;
            end
            ST_HRD:
            begin
                if (g_in_range)
                begin
                    hist_ctrl.rd_en   = 1'b1;
                    hist_ctrl.rd_addr = HIST_AW'(g_m1[IDX_W-1:0]);
                    state_next        = ST_HWR;
                end
                else
                begin
                    state_next = ST_NXT;
                end
            end
            ST_HWR:
            begin
                hist_ctrl.wr_en   = 1'b1;
                hist_ctrl.wr_addr = HIST_AW'(g_m1[IDX_W-1:0]);
                hist_ctrl.wr_data = hist_rd_data + 1'b1;
                state_next        = ST_NXT;
            end
            ST_NXT:
            begin
                if (CNT_W'(idx_reg) == item_cnt_reg)
                begin
                    item_cnt_next = item_cnt_reg + 1'b1;
                    if (last_reg)
                    begin
                        d_next     = CNT_W'(1);
                        state_next = ST_ERD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = (CNT_W'(idx_inc) == item_cnt_reg) ? ST_NEW : ST_RD;
                end
            end
            ST_ERD:
            begin
                hist_ctrl.rd_en   = 1'b1;
                hist_ctrl.rd_addr = HIST_AW'(d_m1[IDX_W-1:0]);
                state_next        = ST_ELD;
            end
            ST_ELD:
            begin
                out_valid_next = 1'b1;
                out_div_next   = DIV_W'(d_reg);
                out_cnt_next   = hist_rd_data;
                out_ovf_next   = drop_reg;
                out_fin_next   = (d_reg == item_cnt_reg);
                state_next     = ST_EWAIT;
            end
            ST_EWAIT:
            begin
                if (out_ch.ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_fin_reg)
                    begin
                        hist_ctrl.clear = 1'b1;
                        item_cnt_next   = '0;
                        drop_next       = 1'b0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        d_next     = d_reg + 1'b1;
                        state_next = ST_ERD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            item_cnt_reg  <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            item_cnt_reg  <= item_cnt_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        d_reg       <= d_next;
        last_reg    <= last_next;
        v_reg       <= v_next;
        g_reg       <= g_next;
        out_div_reg <= out_div_next;
        out_cnt_reg <= out_cnt_next;
        out_ovf_reg <= out_ovf_next;
        out_fin_reg <= out_fin_next;
    end

    // running GCD store
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            gcd_mem[idx_reg] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            gcd_rd_reg <= gcd_mem[idx_reg];
        end
    end

    assign in_ch.ready       = (state_reg == ST_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.divisor    = out_div_reg;
    assign out_ch.count      = out_cnt_reg;
    assign out_ch.overflowed = out_ovf_reg;
    assign out_ch.final_res  = out_fin_reg;
endmodule

// ===== bench/subarray_gcd_histogram_tb.sv =====
// Testbench: subarray GCD histogram, directed and random word sequences checked against a running-GCD predictor.
`timescale 1ns / 1ps

module subarray_gcd_histogram_tb;
    import sgh_pkg::*;

    localparam int MAX_LEN      = 64;
    localparam int VALUE_BITS   = 16;
    localparam int TARGET_WORDS = 210;
    localparam int CALM_WORDS   = 30;
    localparam int STALL_LIMIT  = 30000;
    localparam int DRAIN_CYCLES = 3000;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } element_t;

    typedef struct packed {
        logic [DIV_W-1:0]   divisor;
        logic [COUNT_W-1:0] count;
        logic               overflowed;
        logic               final_res;
    } bin_word_t;

    logic clk;
    logic rst_n;

    sgh_in_if  in_ch();
    sgh_out_if out_ch();

    subarray_gcd_histogram #(
        .MAX_LEN    (MAX_LEN),
        .VALUE_BITS (VALUE_BITS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    element_t  word_queue[$];
    bin_word_t expected_bins[$];

    // predictor state
    logic [VALUE_W-1:0] gcd_run[MAX_LEN];
    logic [COUNT_W-1:0] gcd_bins[MAX_LEN];
    int                 stored;
    logic               dropped;

    int total_words;
    int words_in;
    int results_seen;
    int sequences_done;
    int dropped_words;
    int errors;
    int send_gap;
    int recv_gap;
    int stall_cycles;
    logic quiet;

    assign quiet = (total_words - words_in) <= CALM_WORDS;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [VALUE_W-1:0] common_divisor(logic [VALUE_W-1:0] a,
                                                          logic [VALUE_W-1:0] b);
        logic [VALUE_W-1:0] t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    task automatic clear_histogram();
        for (int i = 0; i < MAX_LEN; i++)
        begin
            gcd_run[i]  = '0;
            gcd_bins[i] = '0;
        end
        stored  = 0;
        dropped = 1'b0;
    endtask

    // fold one accepted word into the running GCDs (or mark it dropped when full); on last, queue the divisor counts
    task automatic absorb_element(input logic [VALUE_W-1:0] v, input logic fin);
        bin_word_t w;
        logic [VALUE_W-1:0] g;
        if (stored < MAX_LEN)
        begin
            for (int i = 0; i < stored; i++)
                gcd_run[i] = common_divisor(gcd_run[i], v);
            gcd_run[stored] = v;
            stored++;
            for (int i = 0; i < stored; i++)
            begin
                g = gcd_run[i];
                if (g >= 1 && g <= MAX_LEN)
                    gcd_bins[g-1] = gcd_bins[g-1] + 1'b1;
            end
        end
        else
        begin
            dropped = 1'b1;
            dropped_words++;
        end
        if (fin)
        begin
            for (int d = 1; d <= stored; d++)
            begin
                w.divisor    = DIV_W'(d);
                w.count      = gcd_bins[d-1];
                w.overflowed = dropped;
                w.final_res  = (d == stored);
                expected_bins.push_back(w);
            end
            sequences_done++;
            clear_histogram();
        end
    endtask

    function automatic logic [VALUE_W-1:0] gen_value(int style);
        int g;
        case (style)
            0: return VALUE_W'($urandom_range(1, 65535));
            1:
            begin
                g = $urandom_range(1, 16);
                return VALUE_W'(g * $urandom_range(1, 65535 / g));
            end
            2: return VALUE_W'($urandom_range(1, 64));
            default: return VALUE_W'((1 << $urandom_range(0, 6)) * $urandom_range(1, 3));
        endcase
    endfunction

    task automatic push_word(input logic [VALUE_W-1:0] v, input logic fin);
        word_queue.push_back('{v, fin});
    endtask

    task automatic queue_sequence(input int len, input int style);
        for (int i = 0; i < len; i++)
            push_word(gen_value(style), i == len - 1);
    endtask

    // driver
    always @(posedge clk)
    begin : drive
        logic     nv;
        element_t nxt;
        nv  = in_ch.valid;
        nxt = '{in_ch.value, in_ch.last};
        if (!rst_n)
            nv = 1'b0;
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                absorb_element(in_ch.value, in_ch.last);
                words_in++;
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (word_queue.size() > 0)
                begin
                    if (!quiet && $urandom_range(0, 4) == 0)
                        send_gap = $urandom_range(0, 9);
                    else
                    begin
                        nxt = word_queue.pop_front();
                        nv  = 1'b1;
                    end
                end
            end
        end
        in_ch.valid <= nv;
        in_ch.value <= nxt.value;
        in_ch.last  <= nxt.last;
    end

    // monitor
    always @(posedge clk)
    begin : observe
        logic      nr;
        bin_word_t got;
        bin_word_t want;
        nr = out_ch.ready;
        if (!rst_n)
            nr = 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.divisor, out_ch.count, out_ch.overflowed, out_ch.final_res};
                results_seen++;
                if (expected_bins.size() == 0)
                begin
                    $display("%0t: unexpected result word, actual %p", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_bins.pop_front();
                    if (got.divisor !== want.divisor)
                    begin
                        $display("%0t: divisor expected %0d actual %0d",
                                 $time, want.divisor, got.divisor);
                        errors++;
                    end
                    if (got.count !== want.count)
                    begin
                        $display("%0t: count (divisor %0d) expected %0d actual %0d",
                                 $time, want.divisor, want.count, got.count);
                        errors++;
                    end
                    if (got.overflowed !== want.overflowed)
                    begin
                        $display("%0t: overflowed (divisor %0d) expected %0b actual %0b",
                                 $time, want.divisor, want.overflowed, got.overflowed);
                        errors++;
                    end
                    if (got.final_res !== want.final_res)
                    begin
                        $display("%0t: final_res (divisor %0d) expected %0b actual %0b",
                                 $time, want.divisor, want.final_res, got.final_res);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                nr = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                recv_gap = $urandom_range(0, 9);
                nr = 1'b0;
            end
            else
                nr = 1'b1;
        end
        out_ch.ready <= nr;
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int len;
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.value    = '0;
        in_ch.last     = 1'b0;
        out_ch.ready   = 1'b0;
        total_words    = 0;
        words_in       = 0;
        results_seen   = 0;
        sequences_done = 0;
        dropped_words  = 0;
        errors         = 0;
        send_gap       = 0;
        recv_gap       = 0;
        stall_cycles   = 0;
        clear_histogram();

        // directed: single words at both ends, all-bits patterns, zeros, large GCDs
        push_word(16'd1, 1'b1);
        push_word(16'd65535, 1'b1);
        push_word(16'hFFFF, 1'b0);
        push_word(16'h8000, 1'b0);
        push_word(16'h0001, 1'b0);
        push_word(16'h5555, 1'b1);
        push_word(16'd0, 1'b0);
        push_word(16'd0, 1'b1);
        push_word(16'd0, 1'b0);
        push_word(16'd6, 1'b0);
        push_word(16'd0, 1'b0);
        push_word(16'd9, 1'b1);
        push_word(16'd40, 1'b0);
        push_word(16'd40, 1'b0);
        push_word(16'd40, 1'b1);
        push_word(16'd48, 1'b0);
        push_word(16'd32, 1'b0);
        push_word(16'd16, 1'b0);
        push_word(16'd64, 1'b0);
        push_word(16'd8, 1'b0);
        push_word(16'hAAAA, 1'b0);
        push_word(16'd2, 1'b1);

        // random sequences, one long run past the length limit in the middle
        while (word_queue.size() < 90)
        begin
            len = $urandom_range(0, 3) == 0 ? $urandom_range(11, 20) : $urandom_range(1, 10);
            queue_sequence(len, $urandom_range(0, 3));
        end
        queue_sequence(MAX_LEN + $urandom_range(1, 4), 2);
        while (word_queue.size() < TARGET_WORDS)
            queue_sequence($urandom_range(1, 10), $urandom_range(0, 3));
        total_words = word_queue.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        wait (words_in == total_words && expected_bins.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_bins.size() != 0)
        begin
            $display("%0t: %0d result words never arrived, next expected %p",
                     $time, expected_bins.size(), expected_bins[0]);
            errors++;
        end
        $display("Covered %0d sequences, %0d input words (%0d dropped past the length limit),",
                 sequences_done, words_in, dropped_words);
        $display("and checked %0d divisor-count words.", results_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sgh_pkg.sv
hw/rtl/sgh_intf.sv
hw/rtl/sgh_gcd_unit.sv
hw/rtl/sgh_hist_mem.sv
hw/rtl/subarray_gcd_histogram.sv
bench/subarray_gcd_histogram_tb.sv
